@@ rtl/vrt_pkg.sv @@
// vrt_pkg: shared widths, face codes and divider handshake type
// for the voxel ray traversal unit; no dependencies
package vrt_pkg;

	localparam int DIR_W    = 16;
	localparam int CELL_W   = 16;
	localparam int ORG_W    = 32;
	localparam int MAXD_W   = 21;
	localparam int EYE_W    = 18;
	localparam int FACE_W   = 3;
	localparam int DIR_FRAC = 14;

	localparam logic [FACE_W-1:0] FACE_START  = 3'd0;
	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd3;
	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd4;
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd6;

	localparam logic [0:0] REG_MAXD = 1'b0;
	localparam logic [0:0] REG_EYE  = 1'b1;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	// face entered when stepping along axis (0 x, 1 y, 2 z)
	function automatic logic [FACE_W-1:0] face_code(input logic [1:0] axis, input logic pos);
		logic [FACE_W-1:0] f;
		unique case (axis)
			2'd0:    f = pos ? FACE_LEFT : FACE_RIGHT;
			2'd1:    f = pos ? FACE_BOTTOM : FACE_TOP;
			default: f = pos ? FACE_BACK : FACE_FRONT;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/vrt_cfg.sv @@
// vrt_cfg: apb register file holding max_distance and eye_offset
// depends on vrt_pkg
module vrt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic [vrt_pkg::MAXD_W-1:0] max_distance,
	output logic [vrt_pkg::EYE_W-1:0]  eye_offset
);

	logic [vrt_pkg::MAXD_W-1:0] maxd_q;
	logic [vrt_pkg::EYE_W-1:0]  eye_q;
	logic                       wr;

	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxd_q <= vrt_pkg::MAXD_W'(262144);
			eye_q  <= vrt_pkg::EYE_W'(47186);
		end else if (wr) begin
			if (paddr[2] == vrt_pkg::REG_MAXD)
				maxd_q <= pwdata[vrt_pkg::MAXD_W-1:0];
			else
				eye_q <= pwdata[vrt_pkg::EYE_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == vrt_pkg::REG_MAXD)
			prdata = {{(32-vrt_pkg::MAXD_W){1'b0}}, maxd_q};
		else
			prdata = {{(32-vrt_pkg::EYE_W){1'b0}}, eye_q};
	end

	assign max_distance = maxd_q;
	assign eye_offset   = eye_q;

endmodule

@@ rtl/vrt_div.sv @@
// vrt_div: restoring divider, one quotient bit per cycle
// depends on vrt_pkg
module vrt_div #(
	parameter int N = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vrt_pkg::div_ctl_t         ctl_in,
	input  logic [N-1:0]              dividend,
	input  logic [vrt_pkg::DIR_W-1:0] divisor,
	output logic                      done,
	output logic [N-1:0]              quotient
);

	localparam int CNT_W = $clog2(N + 1);

	logic [vrt_pkg::DIR_W-1:0] rem_q;
	logic [N-1:0]              quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic [vrt_pkg::DIR_W:0]   trial;
	logic [vrt_pkg::DIR_W:0]   diff;
	logic                      ge;

	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				cnt_q <= CNT_W'(N);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[vrt_pkg::DIR_W-1:0] : trial[vrt_pkg::DIR_W-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/voxel_ray_traversal_unit.sv @@
// voxel_ray_traversal_unit: 3d dda voxel walker with a shared serial divider
// depends on vrt_pkg, vrt_cfg, vrt_div
//
//  channel  | handshake             | words
//  ray in   | start / busy          | origin_x/y/z, dir_x/y/z
//  voxel out| valid (one cycle)     | voxel_x/y/z, entry_face, entry_distance, last
//  config   | apb psel/penable      | max_distance @0, eye_offset @4
//
// a ray runs six divisions on the one shared divider (tmax and delta per axis),
// then emits one voxel per cycle.
// busy stays high from accept until the last voxel is issued.
// reset clears the sequencer and loads the register defaults.
// the receiver cannot stall: every voxel word is shown for exactly one cycle.
module voxel_ray_traversal_unit #(
	parameter int MAX_VOXELS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          origin_x,
	input  logic signed [31:0]          origin_y,
	input  logic signed [31:0]          origin_z,
	input  logic signed [15:0]          dir_x,
	input  logic signed [15:0]          dir_y,
	input  logic signed [15:0]          dir_z,
	output logic                        valid,
	output logic signed [15:0]          voxel_x,
	output logic signed [15:0]          voxel_y,
	output logic signed [15:0]          voxel_z,
	output logic [2:0]                  entry_face,
	output logic [20:0]                 entry_distance,
	output logic                        last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int N    = FRAC_BITS + vrt_pkg::DIR_FRAC + 1;
	localparam int TW   = FRAC_BITS + 16;
	localparam int CW   = $clog2(MAX_VOXELS + 1);
	localparam int WIDE = 48;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_STEP = 2'd3;

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [1:0]                        state_q;
	logic [2:0]                        idx_q;
	logic [CW-1:0]                     n_q;
	logic [vrt_pkg::CELL_W-1:0]        cell_q  [3];
	logic [FRAC_BITS-1:0]              frac_q  [3];
	logic [vrt_pkg::DIR_W-1:0]         dir_q   [3];
	logic [TW-1:0]                     tmax_q  [3];
	logic [TW-1:0]                     delta_q [3];
	logic [vrt_pkg::FACE_W-1:0]        face_q;
	logic [vrt_pkg::MAXD_W-1:0]        dist_q;

	logic                              valid_q;
	logic [vrt_pkg::CELL_W-1:0]        vx_q, vy_q, vz_q;
	logic [vrt_pkg::FACE_W-1:0]        ofc_q;
	logic [vrt_pkg::MAXD_W-1:0]        odist_q;
	logic                              olast_q;

	logic [vrt_pkg::MAXD_W-1:0]        max_distance;
	logic [vrt_pkg::EYE_W-1:0]         eye_offset;

	logic [WIDE-1:0]                   ox, oy, oz;
	vrt_pkg::div_ctl_t                 dctl;
	logic                              div_done;
	logic [N-1:0]                      div_q;
	logic [1:0]                        dax;
	logic [vrt_pkg::DIR_W-1:0]         ddir;
	logic [vrt_pkg::DIR_W-1:0]         dmag;
	logic [FRAC_BITS:0]                bound;
	logic [N-1:0]                      dividend;

	logic [2:0]                        nz;
	logic                              lt01, lt02, lt12;
	logic [1:0]                        axis;
	logic [TW-1:0]                     tsel;
	logic                              pos;
	logic                              cont;

	vrt_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.max_distance (max_distance),
		.eye_offset   (eye_offset)
	);

	assign pready = 1'b1;

	// origins widened so the cell index is a plain arithmetic floor
	assign ox = {{(WIDE-32){origin_x[31]}}, origin_x};
	assign oy = {{(WIDE-32){origin_y[31]}}, origin_y}
		+ {{(WIDE-vrt_pkg::EYE_W){1'b0}}, eye_offset};
	assign oz = {{(WIDE-32){origin_z[31]}}, origin_z};

	// operand select: idx 0..2 boundary distance, 3..5 per-cell delta
	always_comb begin
		unique case (idx_q)
			3'd0, 3'd3: dax = 2'd0;
			3'd1, 3'd4: dax = 2'd1;
			default:    dax = 2'd2;
		endcase
		ddir = dir_q[dax];
		dmag = ddir[vrt_pkg::DIR_W-1] ? (~ddir + 1'b1) : ddir;
		if (idx_q >= 3'd3)
			bound = ONE;
		else if (!ddir[vrt_pkg::DIR_W-1])
			bound = ONE - {1'b0, frac_q[dax]};
		else
			bound = {1'b0, frac_q[dax]};
		dividend = {bound, {vrt_pkg::DIR_FRAC{1'b0}}};
	end

	assign dctl.start = (state_q == ST_DIV);
	assign dctl.done  = 1'b0;

	vrt_div #(.N(N)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (dctl),
		.dividend (dividend),
		.divisor  (dmag),
		.done     (div_done),
		.quotient (div_q)
	);

	// axis choice: ties go to y over x, z over both; a zero direction wins only when all three are zero
	always_comb begin
		nz[0] = dir_q[0] != '0;
		nz[1] = dir_q[1] != '0;
		nz[2] = dir_q[2] != '0;
		lt01  = nz[0] && (!nz[1] || tmax_q[0] < tmax_q[1]);
		lt02  = nz[0] && (!nz[2] || tmax_q[0] < tmax_q[2]);
		lt12  = nz[1] && (!nz[2] || tmax_q[1] < tmax_q[2]);
		if (lt01)
			axis = lt02 ? 2'd0 : 2'd2;
		else
			axis = lt12 ? 2'd1 : 2'd2;
		tsel = tmax_q[axis];
		pos  = !dir_q[axis][vrt_pkg::DIR_W-1];
		cont = nz[axis] && (tsel <= {{(TW-vrt_pkg::MAXD_W){1'b0}}, max_distance})
			&& (n_q < CW'(MAX_VOXELS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						idx_q   <= '0;
						n_q     <= CW'(1);
					end
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						if (idx_q == 3'd5) begin
							state_q <= ST_STEP;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_STEP: begin
					valid_q <= 1'b1;
					if (cont)
						n_q <= n_q + 1'b1;
					else
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cell_q[0] <= ox[FRAC_BITS +: vrt_pkg::CELL_W];
			cell_q[1] <= oy[FRAC_BITS +: vrt_pkg::CELL_W];
			cell_q[2] <= oz[FRAC_BITS +: vrt_pkg::CELL_W];
			frac_q[0] <= ox[FRAC_BITS-1:0];
			frac_q[1] <= oy[FRAC_BITS-1:0];
			frac_q[2] <= oz[FRAC_BITS-1:0];
			dir_q[0]  <= dir_x;
			dir_q[1]  <= dir_y;
			dir_q[2]  <= dir_z;
			face_q    <= vrt_pkg::FACE_START;
			dist_q    <= '0;
		end
		if (state_q == ST_WAIT && div_done) begin
			if (idx_q >= 3'd3)
				delta_q[dax] <= {{(TW-N){1'b0}}, div_q};
			else
				tmax_q[dax] <= {{(TW-N){1'b0}}, div_q};
		end
		if (state_q == ST_STEP) begin
			vx_q    <= cell_q[0];
			vy_q    <= cell_q[1];
			vz_q    <= cell_q[2];
			ofc_q   <= face_q;
			odist_q <= dist_q;
			olast_q <= !cont;
			if (cont) begin
				cell_q[axis] <= pos ? cell_q[axis] + 1'b1 : cell_q[axis] - 1'b1;
				face_q       <= vrt_pkg::face_code(axis, pos);
				dist_q       <= tsel[vrt_pkg::MAXD_W-1:0];
				tmax_q[axis] <= tsel + delta_q[axis];
			end
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign valid          = valid_q;
	assign voxel_x        = vx_q;
	assign voxel_y        = vy_q;
	assign voxel_z        = vz_q;
	assign entry_face     = ofc_q;
	assign entry_distance = odist_q;
	assign last           = olast_q;

endmodule
